>>> hw/rtl/rs2i_pkg.sv
// Shared types, constants and codes for the radix string to integer core.
package rs2i_pkg;

  // Accumulator width of the magnitude register.
  localparam int ACC_W = 64;
  localparam int VAL_W = 64;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;

  localparam logic [6:0] TB_MIN = 7'd8;
  localparam logic [6:0] TB_MAX = 7'd64;

  typedef enum logic [1:0] {
    RADIX_OCT = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  typedef enum logic [1:0] {
    CFG_RADIX   = 2'd0,
    CFG_TBITS   = 2'd1,
    CFG_TSIGNED = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
    logic       empty_item;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] value_bits;
    logic             status;
  } out_word_t;

  // Finished string handed from the accumulator to the range check.
  typedef struct packed {
    logic [ACC_W-1:0] mag;
    logic             neg;
    logic             bad;
  } fin_t;

endpackage

>>> hw/rtl/radix_string_to_integer_core.sv
// Top level: configuration registers and the two parse stages.
//
//  channel  handshake             payload               direction
//  in_      in_valid/in_ready     in_data (in_word_t)   one character word
//  out_     out_valid/out_ready   out_data (out_word_t) one result per last word
//  cfg_     cfg_valid/cfg_ready   cfg_index, cfg_data   register write
//
// One word is taken every cycle while no last word is held back; the base
// multiply is a shift-and-add in the accumulator stage between the input
// register and the finish register, which feeds the out_ result register.
// Reset (synchronous, rst_n low) clears the string state and loads base ten,
// a 64-bit signed target; there is no clearing pass.
// A stalled output holds the finish register, then a last word in the input
// register, then in_ready; words that are not last keep flowing meanwhile.
module radix_string_to_integer_core import rs2i_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [1:0] radix_r;
  logic [6:0] tbits_r;
  logic       tsigned_r;

  logic       fin_valid;
  logic       fin_ready;
  fin_t       fin_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r   <= RADIX_DEC;
      tbits_r   <= TB_MAX;
      tsigned_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIX:   radix_r   <= cfg_data[1:0];
        CFG_TBITS:   tbits_r   <= cfg_data[6:0];
        CFG_TSIGNED: tsigned_r <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  rs2i_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .radix_sel (radix_r),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin_data  (fin_data)
  );

  rs2i_range u_range (
    .clk        (clk),
    .rst_n      (rst_n),
    .fin_valid  (fin_valid),
    .fin_ready  (fin_ready),
    .fin_data   (fin_data),
    .radix_sel  (radix_r),
    .tgt_bits   (tbits_r),
    .tgt_signed (tsigned_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

>>> hw/rtl/rs2i_acc.sv
// Input register and per-character digit accumulator.
module rs2i_acc import rs2i_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  input  logic [1:0] radix_sel,
  output logic       fin_valid,
  input  logic       fin_ready,
  output fin_t       fin_data
);

  logic             s1_valid_r;
  in_word_t         s1_data_r;
  logic             fin_valid_r;
  fin_t             fin_data_r;

  logic [ACC_W-1:0] mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic             failed_r, failed_nxt;
  logic             at_start_r, at_start_nxt;
  logic             seen_r, seen_nxt;

  logic             fin_free;
  logic             s1_take;
  logic             s1_last;

  logic [7:0]       ch;
  logic [4:0]       dig;
  logic             dig_ok;
  logic [ACC_W+3:0] ext;
  logic [ACC_W+3:0] prod;
  logic [ACC_W+3:0] sum;
  logic             ovf;

  assign s1_last  = s1_data_r.last_char;
  assign fin_free = !fin_valid_r || fin_ready;
  assign s1_take  = s1_valid_r && (!s1_last || fin_free);
  assign in_ready = !s1_valid_r || s1_take;

  assign fin_valid = fin_valid_r;
  assign fin_data  = fin_data_r;

  assign ch = s1_data_r.character;

  // Decode the character, then reject digits at or above the base.
  always_comb begin
    dig    = 5'd0;
    dig_ok = 1'b0;
    if (ch >= CH_0 && ch <= CH_9) begin
      dig    = 5'(ch - CH_0);
      dig_ok = 1'b1;
    end else if (ch >= CH_LA && ch <= CH_LF) begin
      dig    = 5'(ch - CH_LA) + 5'd10;
      dig_ok = 1'b1;
    end else if (ch >= CH_UA && ch <= CH_UF) begin
      dig    = 5'(ch - CH_UA) + 5'd10;
      dig_ok = 1'b1;
    end
    unique case (radix_sel)
      RADIX_OCT: if (dig >= 5'd8)  dig_ok = 1'b0;
      RADIX_DEC: if (dig >= 5'd10) dig_ok = 1'b0;
      RADIX_HEX: ;
      default:   dig_ok = 1'b0;
    endcase
  end

  // Multiply by the base with shifts and at most one add, then add the digit; spill bits flag overflow.
  always_comb begin
    ext = (ACC_W+4)'(mag_r);
    unique case (radix_sel)
      RADIX_OCT: prod = ext << 3;
      RADIX_DEC: prod = (ext << 3) + (ext << 1);
      default:   prod = ext << 4;
    endcase
    sum = prod + (ACC_W+4)'(dig);
    ovf = |sum[ACC_W+3:ACC_W];
  end

  always_comb begin
    mag_nxt      = mag_r;
    neg_nxt      = neg_r;
    failed_nxt   = failed_r;
    at_start_nxt = at_start_r;
    seen_nxt     = seen_r;
    if (!s1_data_r.empty_item && !failed_r) begin
      at_start_nxt = 1'b0;
      if (at_start_r && (ch == CH_MINUS || ch == CH_PLUS)) begin
        neg_nxt = (ch == CH_MINUS);
      end else if (!dig_ok || ovf) begin
        failed_nxt = 1'b1;
      end else begin
        mag_nxt  = sum[ACC_W-1:0];
        seen_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fin_valid_r <= 1'b0;
      mag_r       <= '0;
      neg_r       <= 1'b0;
      failed_r    <= 1'b0;
      at_start_r  <= 1'b1;
      seen_r      <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (fin_free) begin
        fin_valid_r <= s1_take && s1_last;
      end
      if (s1_take) begin
        if (s1_last) begin
          // Drop the string state once the word that ends it is taken.
          mag_r      <= '0;
          neg_r      <= 1'b0;
          failed_r   <= 1'b0;
          at_start_r <= 1'b1;
          seen_r     <= 1'b0;
        end else begin
          mag_r      <= mag_nxt;
          neg_r      <= neg_nxt;
          failed_r   <= failed_nxt;
          at_start_r <= at_start_nxt;
          seen_r     <= seen_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_take && s1_last) begin
      fin_data_r.mag <= mag_nxt;
      fin_data_r.neg <= neg_nxt;
      fin_data_r.bad <= failed_nxt || !seen_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take && s1_last |=> at_start_r && !failed_r && !seen_r && mag_r == '0)
    else $error("string state not cleared after last word");

  a_seen_not_start: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_r || failed_r) |-> !at_start_r)
    else $error("digit or failure recorded while at start");

  a_last_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last && fin_valid_r && !fin_ready |=> s1_valid_r && fin_valid_r)
    else $error("last word moved while finish slot full");

endmodule

>>> hw/rtl/rs2i_range.sv
// Target range check, sign application and result register.
module rs2i_range import rs2i_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fin_valid,
  output logic       fin_ready,
  input  fin_t       fin_data,
  input  logic [1:0] radix_sel,
  input  logic [6:0] tgt_bits,
  input  logic       tgt_signed,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data
);

  logic             out_valid_r;
  out_word_t        out_data_r;

  logic [6:0]       tb;
  logic [6:0]       sh;
  logic [VAL_W-1:0] mag64;
  logic             over_s;
  logic             at_min;
  logic             over_u;
  logic             bad;
  logic [VAL_W-1:0] value;

  assign fin_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (tgt_bits < TB_MIN) begin
      tb = TB_MIN;
    end else if (tgt_bits > TB_MAX) begin
      tb = TB_MAX;
    end else begin
      tb = tgt_bits;
    end
    sh     = tb - 7'd1;
    mag64  = VAL_W'(fin_data.mag);
    over_s = (mag64 >> sh) != '0;
    at_min = mag64 == (VAL_W'(1) << sh);
    over_u = (mag64 >> tb) != '0;
    bad    = fin_data.bad || (radix_sel > RADIX_HEX);
    value  = mag64;
    if (tgt_signed) begin
      if (fin_data.neg) begin
        if (over_s && !at_min) bad = 1'b1;
        value = '0 - mag64;
      end else if (over_s) begin
        bad = 1'b1;
      end
    end else if (fin_data.neg || over_u) begin
      bad = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_ready) begin
      out_valid_r <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      out_data_r.value_bits <= bad ? '0 : value;
      out_data_r.status     <= bad;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status |-> out_data_r.value_bits == '0)
    else $error("failed word carries nonzero value");

  a_fin_moves: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid && !out_valid_r |=> out_valid_r)
    else $error("finished string not registered with output free");

  a_unsigned_fits: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid && fin_ready && !tgt_signed && !bad && tb < TB_MAX
      |=> (out_data_r.value_bits >> $past(tb)) == '0)
    else $error("unsigned result exceeds target width");

endmodule
